[rtl/core/btpe_pkg.sv]
// Shared types, constants and helpers for the bitmap text pixel expander.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package btpe_pkg;

    localparam int MAX_GLYPH_DIM_DEF = 32;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic [10:0] COORD_MAX  = 11'd2047;
    localparam logic [2:0]  BIT_MASK   = 3'd7;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd7;

    typedef logic [15:0] t_color;
    typedef logic [10:0] t_coord;

    // geometry registers seen by the front end
    typedef struct packed {
        logic [5:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [9:0]  origin_x;
        logic [9:0]  origin_y;
        logic [10:0] screen_width;
        logic [10:0] screen_height;
    } t_geom;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0]  bits;
        logic [11:0] xs;      // unsaturated column of the byte's first pixel
        t_coord      py;
        logic [2:0]  cnt_m1;  // pixel count minus one
        logic        done;    // byte closes the glyph
    } t_desc;

    function automatic t_coord sat_add(input t_coord a, input logic [11:0] b);
        logic [12:0] s;
        s = {2'b00, a} + {1'b0, b};
        return (s > {2'b00, COORD_MAX}) ? COORD_MAX : s[10:0];
    endfunction

endpackage

`default_nettype wire

[rtl/core/btpe_if.sv]
// Stream interfaces: glyph byte words in, pixel words out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface btpe_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] glyph_byte;
    logic       string_start;

    modport source (output valid, output glyph_byte, output string_start, input ready);
    modport sink   (input valid, input glyph_byte, input string_start, output ready);
endinterface

interface btpe_pix_if;
    logic        valid;
    logic        ready;
    logic [10:0] pixel_x;
    logic [10:0] pixel_y;
    logic [15:0] pixel_color;
    logic        last_of_byte;
    logic        last_of_glyph;

    modport source (output valid, output pixel_x, output pixel_y, output pixel_color,
                    output last_of_byte, output last_of_glyph, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input pixel_color,
                    input last_of_byte, input last_of_glyph, output ready);
endinterface

`default_nettype wire

[rtl/core/btpe_front.sv]
// Front end: cursor, wrap and row/byte tracking; classifies each glyph byte.
// Depends on btpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btpe_front #(
    parameter int MAX_GLYPH_DIM = btpe_pkg::MAX_GLYPH_DIM_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire btpe_pkg::t_geom i_geom,
    input  wire logic           i_clr,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_glyph_byte,
    input  wire logic           i_string_start,
    input  wire logic           i_q_full,
    output logic                o_ready,
    output logic                o_push,
    output btpe_pkg::t_desc     o_desc
);

    localparam int DIM_W = $clog2(MAX_GLYPH_DIM + 1);
    localparam int RW    = $clog2(MAX_GLYPH_DIM);
    localparam int BIR_W = (MAX_GLYPH_DIM > 8) ? $clog2((MAX_GLYPH_DIM + 7) / 8) : 1;

    btpe_pkg::t_coord r_cx, r_cy, n_cx, n_cy;
    logic [RW-1:0]    r_row, n_row;
    logic [BIR_W-1:0] r_bir, n_bir;

    logic [DIM_W-1:0] w, h;
    logic [11:0]      wx, hx, basex, diff, bpr;
    btpe_pkg::t_coord s_cx, s_cy, a_cx, a_cy;
    logic [RW-1:0]    s_row;
    logic [BIR_W-1:0] s_bir;
    logic             s_first, lbr, done, acc;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [5:0] v);
        if (v == 6'd0) return DIM_W'(1);
        if (8'(v) > 8'(MAX_GLYPH_DIM)) return DIM_W'(MAX_GLYPH_DIM);
        return DIM_W'(v);
    endfunction

    assign o_ready = !i_q_full;
    assign acc     = i_valid && o_ready;
    assign o_push  = acc;

    always_comb begin
        w  = clamp_dim(i_geom.glyph_width);
        h  = clamp_dim(i_geom.glyph_height);
        wx = 12'(w);
        hx = 12'(h);

        s_cx    = i_string_start ? {1'b0, i_geom.origin_x} : r_cx;
        s_cy    = i_string_start ? {1'b0, i_geom.origin_y} : r_cy;
        s_row   = i_string_start ? '0 : r_row;
        s_bir   = i_string_start ? '0 : r_bir;
        s_first = (s_row == '0) && (s_bir == '0);

        a_cx = s_cx;
        a_cy = s_cy;
        if (s_first) begin
            if (12'(s_cx) + wx > 12'(i_geom.screen_width)) begin
                a_cx = {1'b0, i_geom.origin_x};
                a_cy = btpe_pkg::sat_add(s_cy, hx);
            end
            if (12'(a_cy) + hx > 12'(i_geom.screen_height)) begin
                a_cx = {1'b0, i_geom.origin_x};
                a_cy = {1'b0, i_geom.origin_y};
            end
        end

        basex = 12'({s_bir, 3'b000});
        diff  = wx - basex;
        bpr   = (wx + 12'd7) >> 3;
        lbr   = (12'(s_bir) + 12'd1) >= bpr;
        done  = lbr && ((12'(s_row) + 12'd1) >= hx);

        o_desc.bits = i_glyph_byte;
        o_desc.xs   = 12'(a_cx) + basex;
        o_desc.py   = btpe_pkg::sat_add(a_cy, 12'(s_row));
        o_desc.done = done;
        if (wx > basex) begin
            o_desc.cnt_m1 = (diff > 12'd8) ? btpe_pkg::BIT_MASK : 3'(diff - 12'd1);
        end else begin
            o_desc.cnt_m1 = 3'd0;
        end

        n_cx  = a_cx;
        n_cy  = a_cy;
        n_row = s_row;
        n_bir = s_bir;
        if (!lbr) begin
            n_bir = s_bir + 1'b1;
        end else begin
            n_bir = '0;
            if (done) begin
                n_row = '0;
                n_cx  = btpe_pkg::sat_add(a_cx, wx);
            end else begin
                n_row = s_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_row <= '0;
            r_bir <= '0;
        end else if (acc) begin
            r_cx  <= n_cx;
            r_cy  <= n_cy;
            r_row <= n_row;
            r_bir <= n_bir;
        end else if (i_clr) begin
            r_row <= '0;
            r_bir <= '0;
        end
    end

endmodule

`default_nettype wire

[rtl/core/btpe_queue.sv]
// Short queue of classified byte words between front and back end.
// Depends on btpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btpe_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire btpe_pkg::t_desc i_desc,
    input  wire logic            i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output btpe_pkg::t_desc      o_desc
);

    localparam int DEPTH = btpe_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    btpe_pkg::t_desc   r_mem [DEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [PW:0]       r_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_desc  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ptr_inc(r_wp);
            if (i_pop)  r_rp <= ptr_inc(r_rp);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/btpe_back.sv]
// Back end: expands one classified byte into pixels, one per cycle while the
// receiver is ready, into a registered output. Depends on btpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btpe_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire btpe_pkg::t_color i_fg,
    input  wire btpe_pkg::t_color i_bg,
    input  wire logic            i_q_valid,
    input  wire btpe_pkg::t_desc i_q_desc,
    output logic                 o_q_pop,
    input  wire logic            i_ready,
    output logic                 o_valid,
    output btpe_pkg::t_coord     o_pixel_x,
    output btpe_pkg::t_coord     o_pixel_y,
    output btpe_pkg::t_color     o_pixel_color,
    output logic                 o_last_of_byte,
    output logic                 o_last_of_glyph
);

    btpe_pkg::t_desc r_d;
    logic [2:0]      r_k;
    logic            r_busy, r_vld;
    logic            adv, fire, last, load;

    assign adv     = !r_vld || i_ready;
    assign fire    = r_busy && adv;
    assign last    = (r_k == r_d.cnt_m1);
    assign load    = i_q_valid && (!r_busy || (fire && last));
    assign o_q_pop = load;
    assign o_valid = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_vld  <= 1'b0;
            r_k    <= '0;
        end else begin
            if (adv) r_vld <= r_busy;
            if (load) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else begin
                if (fire) r_k <= r_k + 1'b1;
                if (fire && last) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_d <= i_q_desc;
        if (fire) begin
            o_pixel_x       <= btpe_pkg::sat_add(r_d.xs[10:0], {r_d.xs[11], 11'd0} + 12'(r_k));
            o_pixel_y       <= r_d.py;
            o_pixel_color   <= r_d.bits[btpe_pkg::BIT_MASK - r_k] ? i_fg : i_bg;
            o_last_of_byte  <= last;
            o_last_of_glyph <= last && r_d.done;
        end
    end

endmodule

`default_nettype wire

[rtl/core/bitmap_text_pixel_expander.sv]
// Bitmap text pixel expander, top level: configuration registers, front end,
// queue and back end. Depends on btpe_pkg, btpe_if, btpe_front, btpe_queue, btpe_back.
//
// i_byte takes glyph bitmap words (bit 7 leftmost, rows padded to whole bytes);
// string_start puts the cursor at the origin before that word. o_pix gives one
// word per covered glyph pixel: screen x/y (saturating at 2047), colour, and
// end-of-byte / end-of-glyph flags. Both channels complete on valid && ready.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
// them only while the block is idle, which the block itself does not enforce; writing
// glyph width or height restarts the glyph at the current cursor.
// The first pixel of a byte passes the queue, the back end's byte register and the
// output register. Throughput: one pixel per cycle while the receiver is ready, set
// by the back end's pixel counter. A two-entry queue lets bytes be taken while
// earlier ones are still expanding.
// Reset clears the cursor, the row/byte counters, the queue and the output and
// loads register defaults. When the receiver stalls the output word holds,
// the queue fills, then i_byte.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_text_pixel_expander #(
    parameter int MAX_GLYPH_DIM = btpe_pkg::MAX_GLYPH_DIM_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    btpe_byte_if.sink                            i_byte,
    btpe_pix_if.source                           o_pix,
    input  wire logic                            i_cfg_we,
    input  wire logic [btpe_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [btpe_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    btpe_pkg::t_color r_fg, r_bg;
    btpe_pkg::t_geom  r_geom;
    logic             clr;

    logic             q_full, q_valid, push, pop;
    btpe_pkg::t_desc  f_desc, q_desc;

    assign clr = i_cfg_we && ((i_cfg_idx == btpe_pkg::CFG_GLYPH_WIDTH) ||
                              (i_cfg_idx == btpe_pkg::CFG_GLYPH_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg                 <= 16'hFFFF;
            r_bg                 <= 16'h0000;
            r_geom.glyph_width   <= 6'd8;
            r_geom.glyph_height  <= 6'd8;
            r_geom.origin_x      <= 10'd0;
            r_geom.origin_y      <= 10'd0;
            r_geom.screen_width  <= 11'd240;
            r_geom.screen_height <= 11'd240;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                btpe_pkg::CFG_FG_COLOR:      r_fg                 <= i_cfg_data;
                btpe_pkg::CFG_BG_COLOR:      r_bg                 <= i_cfg_data;
                btpe_pkg::CFG_GLYPH_WIDTH:   r_geom.glyph_width   <= i_cfg_data[5:0];
                btpe_pkg::CFG_GLYPH_HEIGHT:  r_geom.glyph_height  <= i_cfg_data[5:0];
                btpe_pkg::CFG_ORIGIN_X:      r_geom.origin_x      <= i_cfg_data[9:0];
                btpe_pkg::CFG_ORIGIN_Y:      r_geom.origin_y      <= i_cfg_data[9:0];
                btpe_pkg::CFG_SCREEN_WIDTH:  r_geom.screen_width  <= i_cfg_data[10:0];
                btpe_pkg::CFG_SCREEN_HEIGHT: r_geom.screen_height <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    btpe_front #(
        .MAX_GLYPH_DIM(MAX_GLYPH_DIM)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (r_geom),
        .i_clr          (clr),
        .i_valid        (i_byte.valid),
        .i_glyph_byte   (i_byte.glyph_byte),
        .i_string_start (i_byte.string_start),
        .i_q_full       (q_full),
        .o_ready        (i_byte.ready),
        .o_push         (push),
        .o_desc         (f_desc)
    );

    btpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (f_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (q_desc)
    );

    btpe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fg            (r_fg),
        .i_bg            (r_bg),
        .i_q_valid       (q_valid),
        .i_q_desc        (q_desc),
        .o_q_pop         (pop),
        .i_ready         (o_pix.ready),
        .o_valid         (o_pix.valid),
        .o_pixel_x       (o_pix.pixel_x),
        .o_pixel_y       (o_pix.pixel_y),
        .o_pixel_color   (o_pix.pixel_color),
        .o_last_of_byte  (o_pix.last_of_byte),
        .o_last_of_glyph (o_pix.last_of_glyph)
    );

endmodule

`default_nettype wire

[tb/sv/tb_bitmap_text_pixel_expander.sv]
// Self-checking testbench for bitmap_text_pixel_expander: glyph byte words in,
// pixel words checked against an in-bench cursor/expansion predictor.
// Depends on btpe_pkg, btpe_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_bitmap_text_pixel_expander;
    import btpe_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES         = 10;
    localparam int PHASE_WORDS    = 50;

    typedef struct packed {
        logic [10:0] x;
        logic [10:0] y;
        logic [15:0] color;
        logic        end_byte;
        logic        end_glyph;
    } pixel_word_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    btpe_byte_if byte_if ();
    btpe_pix_if  pix_if ();

    bitmap_text_pixel_expander DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_if),
        .o_pix      (pix_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of registers and cursor
    logic [15:0] fg_reg, bg_reg;
    logic [5:0]  gw_reg, gh_reg;
    logic [9:0]  ox_reg, oy_reg;
    logic [10:0] sw_reg, sh_reg;
    logic [10:0] cur_x, cur_y;
    logic [4:0]  glyph_row;
    logic [1:0]  row_byte;

    pixel_word_t pix_expected[$];
    int          fail_count = 0;
    int          pix_count = 0;
    bit          fast_mode = 1'b0;

    function automatic int dim_in_use(input logic [5:0] v);
        if (v == 6'd0) return 1;
        if (v > MAX_GLYPH_DIM_DEF) return MAX_GLYPH_DIM_DEF;
        return int'(v);
    endfunction

    function automatic logic [10:0] clip_coord(input int v);
        if (v > int'(COORD_MAX)) return COORD_MAX;
        return 11'(v);
    endfunction

    function automatic int pick_gap();
        int r;
        if (fast_mode) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [5:0] pick_extreme_dim();
        case ($urandom_range(0, 4))
            0: return 6'd0;
            1: return 6'd1;
            2: return 6'd32;
            3: return 6'd33;
            default: return 6'd63;
        endcase
    endfunction

    task automatic reset_model();
        fg_reg    = 16'hFFFF;
        bg_reg    = 16'h0000;
        gw_reg    = 6'd8;
        gh_reg    = 6'd8;
        ox_reg    = '0;
        oy_reg    = '0;
        sw_reg    = 11'd240;
        sh_reg    = 11'd240;
        cur_x     = '0;
        cur_y     = '0;
        glyph_row = '0;
        row_byte  = '0;
    endtask

    task automatic report_mismatch(input string msg);
        if (fail_count < 40) $display("mismatch: %s", msg);
        fail_count++;
    endtask

    // expected pixel words of one accepted glyph byte
    task automatic expand_glyph_byte(input logic [7:0] bits, input logic start);
        int w, h, bpr, base, cnt, k;
        logic row_end, glyph_end;
        logic [10:0] py;
        pixel_word_t p;
        w = dim_in_use(gw_reg);
        h = dim_in_use(gh_reg);
        bpr = (w + 7) / 8;
        if (start) begin
            glyph_row = '0;
            row_byte  = '0;
            cur_x     = 11'(ox_reg);
            cur_y     = 11'(oy_reg);
        end
        if (glyph_row == 5'd0 && row_byte == 2'd0) begin
            if (int'(cur_x) + w > int'(sw_reg)) begin
                cur_x = 11'(ox_reg);
                cur_y = clip_coord(int'(cur_y) + h);
            end
            if (int'(cur_y) + h > int'(sh_reg)) begin
                cur_x = 11'(ox_reg);
                cur_y = 11'(oy_reg);
            end
        end
        base = int'(row_byte) * 8;
        cnt = (w > base) ? w - base : 1;
        if (cnt > 8) cnt = 8;
        row_end   = (int'(row_byte) + 1 >= bpr);
        glyph_end = row_end && (int'(glyph_row) + 1 >= h);
        py = clip_coord(int'(cur_y) + int'(glyph_row));
        for (k = 0; k < cnt; k++) begin
            p.x         = clip_coord(int'(cur_x) + base + k);
            p.y         = py;
            p.color     = bits[7 - k] ? fg_reg : bg_reg;
            p.end_byte  = (k + 1 == cnt);
            p.end_glyph = p.end_byte && glyph_end;
            pix_expected.push_back(p);
        end
        if (!row_end) begin
            row_byte++;
        end else begin
            row_byte = '0;
            if (glyph_end) begin
                glyph_row = '0;
                cur_x = clip_coord(int'(cur_x) + w);
            end else begin
                glyph_row++;
            end
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FG_COLOR:      fg_reg = data;
            CFG_BG_COLOR:      bg_reg = data;
            CFG_GLYPH_WIDTH: begin
                gw_reg = data[5:0];
                glyph_row = '0;
                row_byte = '0;
            end
            CFG_GLYPH_HEIGHT: begin
                gh_reg = data[5:0];
                glyph_row = '0;
                row_byte = '0;
            end
            CFG_ORIGIN_X:      ox_reg = data[9:0];
            CFG_ORIGIN_Y:      oy_reg = data[9:0];
            CFG_SCREEN_WIDTH:  sw_reg = data[10:0];
            CFG_SCREEN_HEIGHT: sh_reg = data[10:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic send_byte(input logic [7:0] bits, input logic start);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_if.valid        <= 1'b1;
        byte_if.glyph_byte   <= bits;
        byte_if.string_start <= start;
        do @(posedge i_clk); while (!byte_if.ready);
        expand_glyph_byte(bits, start);
    endtask

    task automatic wait_idle();
        byte_if.valid <= 1'b0;
        while (pix_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_default_registers();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        // string restart while the glyph is half drawn
        send_byte(8'h81, 1'b1);
    endtask

    task automatic test_color_extremes();
        wait_idle();
        cfg_write(CFG_FG_COLOR, 16'h0000);
        cfg_write(CFG_BG_COLOR, 16'hFFFF);
        cfg_write(CFG_GLYPH_WIDTH, 16'd4);
        cfg_write(CFG_GLYPH_HEIGHT, 16'd1);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h0F, 1'b0);
    endtask

    task automatic test_multi_byte_rows();
        wait_idle();
        cfg_write(CFG_GLYPH_WIDTH, 16'hFFFF);
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        wait_idle();
        cfg_write(CFG_GLYPH_WIDTH, 16'd9);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_zero_dims();
        wait_idle();
        cfg_write(CFG_GLYPH_WIDTH, 16'hFFC0);
        cfg_write(CFG_GLYPH_HEIGHT, 16'hFFC0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    task automatic test_cursor_wrap();
        wait_idle();
        cfg_write(CFG_GLYPH_WIDTH, 16'd4);
        cfg_write(CFG_GLYPH_HEIGHT, 16'd1);
        cfg_write(CFG_ORIGIN_X, 16'd2);
        cfg_write(CFG_ORIGIN_Y, 16'd1);
        cfg_write(CFG_SCREEN_WIDTH, 16'd10);
        cfg_write(CFG_SCREEN_HEIGHT, 16'd3);
        send_byte(8'hC0, 1'b1);
        send_byte(8'h30, 1'b0);
        send_byte(8'h90, 1'b0);   // right edge: next line
        send_byte(8'h60, 1'b0);
        send_byte(8'hF0, 1'b0);   // bottom edge: back to origin
        wait_idle();
        cfg_write(CFG_SCREEN_WIDTH, 16'd0);
        send_byte(8'hA0, 1'b0);
        wait_idle();
        cfg_write(CFG_SCREEN_HEIGHT, 16'd0);
        send_byte(8'h50, 1'b0);
    endtask

    task automatic test_size_write_mid_glyph();
        wait_idle();
        cfg_write(CFG_SCREEN_WIDTH, 16'd240);
        cfg_write(CFG_SCREEN_HEIGHT, 16'd240);
        cfg_write(CFG_GLYPH_WIDTH, 16'd8);
        cfg_write(CFG_GLYPH_HEIGHT, 16'd2);
        send_byte(8'hC3, 1'b1);
        wait_idle();
        cfg_write(CFG_GLYPH_HEIGHT, 16'd2);
        send_byte(8'h3C, 1'b0);
        send_byte(8'h99, 1'b0);
    endtask

    task automatic test_coord_extremes();
        wait_idle();
        cfg_write(CFG_GLYPH_WIDTH, 16'd1);
        cfg_write(CFG_GLYPH_HEIGHT, 16'd1);
        cfg_write(CFG_ORIGIN_X, 16'hFFFF);
        cfg_write(CFG_ORIGIN_Y, 16'hFFFF);
        cfg_write(CFG_SCREEN_WIDTH, 16'hFFFF);
        cfg_write(CFG_SCREEN_HEIGHT, 16'hFFFF);
        send_byte(8'h80, 1'b1);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic apply_random_setting();
        logic [15:0] wd, hd, oxd, oyd, swd, shd, fgd, bgd;
        int w, h, r;
        wd = 16'($urandom());
        hd = 16'($urandom());
        r = $urandom_range(0, 99);
        if (r < 10) wd[5:0] = pick_extreme_dim();
        else if (r < 25) wd[5:0] = 6'($urandom_range(13, 32));
        else wd[5:0] = 6'($urandom_range(1, 12));
        r = $urandom_range(0, 99);
        if (r < 10) hd[5:0] = pick_extreme_dim();
        else if (r < 25) hd[5:0] = 6'($urandom_range(7, 32));
        else hd[5:0] = 6'($urandom_range(1, 6));
        w = dim_in_use(wd[5:0]);
        h = dim_in_use(hd[5:0]);

        r = $urandom_range(0, 99);
        if (r < 10) oxd = 16'($urandom());
        else if (r < 15) oxd = 16'd1023;
        else oxd = 16'($urandom_range(0, 40));
        r = $urandom_range(0, 99);
        if (r < 10) oyd = 16'($urandom());
        else if (r < 15) oyd = 16'd1023;
        else oyd = 16'($urandom_range(0, 40));

        r = $urandom_range(0, 99);
        if (r < 70) swd = 16'(int'(oxd[9:0]) + w * $urandom_range(1, 6) + $urandom_range(0, w));
        else if (r < 80) swd = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
        else swd = 16'($urandom());
        r = $urandom_range(0, 99);
        if (r < 70) shd = 16'(int'(oyd[9:0]) + h * $urandom_range(1, 4) + $urandom_range(0, h));
        else if (r < 80) shd = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'd2047;
        else shd = 16'($urandom());

        fgd = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom());
        bgd = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom());

        cfg_write(CFG_FG_COLOR, fgd);
        cfg_write(CFG_BG_COLOR, bgd);
        cfg_write(CFG_GLYPH_WIDTH, wd);
        cfg_write(CFG_GLYPH_HEIGHT, hd);
        cfg_write(CFG_ORIGIN_X, oxd);
        cfg_write(CFG_ORIGIN_Y, oyd);
        cfg_write(CFG_SCREEN_WIDTH, swd);
        cfg_write(CFG_SCREEN_HEIGHT, shd);
    endtask

    // glyph-aligned words with random bits; now and then a string restart, at a glyph start or mid-glyph
    task automatic send_glyph_words(input int count);
        int n;
        logic st;
        for (n = 0; n < count; n++) begin
            if (glyph_row == 5'd0 && row_byte == 2'd0) st = ($urandom_range(0, 7) == 0);
            else st = ($urandom_range(0, 29) == 0);
            send_byte(8'($urandom()), st);
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            fast_mode = (phase == 4);
            apply_random_setting();
            send_glyph_words(PHASE_WORDS / 2);
            // hold the sender until the pixel stream has drained
            if (phase == 2) wait_idle();
            send_glyph_words(PHASE_WORDS - PHASE_WORDS / 2);
        end
        fast_mode = 1'b0;
    endtask

    initial begin : pix_ready_gen
        int n;
        pix_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            pix_if.ready <= 1'b1;
            n = $urandom_range(1, 16);
            repeat (n) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                pix_if.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin : pixel_check
        pixel_word_t want;
        if (i_rst_n && pix_if.valid && pix_if.ready) begin
            if (pix_expected.size() == 0) begin
                report_mismatch($sformatf("word %0d at (%0d,%0d) with nothing expected",
                                          pix_count, pix_if.pixel_x, pix_if.pixel_y));
            end else begin
                want = pix_expected.pop_front();
                if (pix_if.pixel_x !== want.x)
                    report_mismatch($sformatf("word %0d pixel_x got %0d want %0d",
                                              pix_count, pix_if.pixel_x, want.x));
                if (pix_if.pixel_y !== want.y)
                    report_mismatch($sformatf("word %0d pixel_y got %0d want %0d",
                                              pix_count, pix_if.pixel_y, want.y));
                if (pix_if.pixel_color !== want.color)
                    report_mismatch($sformatf("word %0d pixel_color got %h want %h",
                                              pix_count, pix_if.pixel_color, want.color));
                if (pix_if.last_of_byte !== want.end_byte)
                    report_mismatch($sformatf("word %0d last_of_byte got %b want %b",
                                              pix_count, pix_if.last_of_byte, want.end_byte));
                if (pix_if.last_of_glyph !== want.end_glyph)
                    report_mismatch($sformatf("word %0d last_of_glyph got %b want %b",
                                              pix_count, pix_if.last_of_glyph, want.end_glyph));
            end
            pix_count++;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: %0d cycles without a handshake, %0d words pending",
                 WATCHDOG_LIMIT, pix_expected.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= '0;
        i_cfg_data           <= '0;
        byte_if.valid        <= 1'b0;
        byte_if.glyph_byte   <= '0;
        byte_if.string_start <= 1'b0;
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_registers();
        test_color_extremes();
        test_multi_byte_rows();
        test_zero_dims();
        test_cursor_wrap();
        test_size_write_mid_glyph();
        test_coord_extremes();
        test_random_traffic();
        wait_idle();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
